// File: src/temperature_token_sampler_core_macros.svh
// Assertion macros used by the sampler's selection engine, tts_back.
`ifndef TEMPERATURE_TOKEN_SAMPLER_CORE_MACROS_SVH
`define TEMPERATURE_TOKEN_SAMPLER_CORE_MACROS_SVH

// Implication checked in the same cycle.
`define TTS_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Implication checked in the cycle after the condition.
`define TTS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: src/tts_pkg.sv
// Types, constants and exponent tables of the temperature token sampler.
package tts_pkg;

  localparam int LOGIT_W  = 16;
  localparam int FRAC_W   = 16;
  localparam int TOKEN_W  = 16;
  localparam int TEMP_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W    = 32;
  localparam int QUO_W    = 12;
  localparam int EXP_W    = 17;
  localparam int EXPI_LEN = 12;

  typedef struct packed {
    logic signed [LOGIT_W-1:0] logit;
    logic                      last_logit;
    logic [FRAC_W-1:0]         random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] token_index;
    logic               greedy_used;
  } out_item_t;

  typedef struct packed {
    logic                      en;
    logic signed [LOGIT_W-1:0] data;
  } store_wr_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_READ,
    B_SETUP,
    B_DIV,
    B_MUL1,
    B_MUL2,
    B_TARGET,
    B_SREAD,
    B_SCMP,
    B_OUT
  } back_state_t;

  function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] i);
    logic [EXP_W-1:0] r;
    unique case (i)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [EXP_W-1:0] exp_hi(input logic [3:0] h);
    logic [EXP_W-1:0] r;
    unique case (h)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd61565;
      4'd2:    r = 17'd57835;
      4'd3:    r = 17'd54331;
      4'd4:    r = 17'd51039;
      4'd5:    r = 17'd47947;
      4'd6:    r = 17'd45042;
      4'd7:    r = 17'd42313;
      4'd8:    r = 17'd39750;
      4'd9:    r = 17'd37341;
      4'd10:   r = 17'd35079;
      4'd11:   r = 17'd32954;
      4'd12:   r = 17'd30957;
      4'd13:   r = 17'd29081;
      4'd14:   r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

  function automatic logic [EXP_W-1:0] exp_lo(input logic [3:0] l);
    logic [EXP_W-1:0] r;
    unique case (l)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd65280;
      4'd2:    r = 17'd65026;
      4'd3:    r = 17'd64772;
      4'd4:    r = 17'd64520;
      4'd5:    r = 17'd64268;
      4'd6:    r = 17'd64018;
      4'd7:    r = 17'd63768;
      4'd8:    r = 17'd63520;
      4'd9:    r = 17'd63272;
      4'd10:   r = 17'd63025;
      4'd11:   r = 17'd62780;
      4'd12:   r = 17'd62535;
      4'd13:   r = 17'd62291;
      4'd14:   r = 17'd62048;
      default: r = 17'd61806;
    endcase
    return r;
  endfunction

endpackage

// File: src/temperature_token_sampler_core.sv
// Top level of the temperature token sampler.
// Logits enter on in_valid/in_stall as in_data, one transfer per cycle while
// in_stall is low; the transfer with last_logit set closes the vocabulary.
// Each vocabulary yields one transfer on out_valid/out_stall with the token.
// The temperature register is written through cfg_we/cfg_wdata; the user
// must write it only while idle, as the block does not enforce this.
// Temperature zero returns the first argmax. Otherwise the engine computes
// one weight per entry (a 12-step serial divide by the temperature plus two
// table multiplies, with the divide and the first multiply skipped when the
// weight is known to be zero), then searches the stored weights in order.
// While such a pass runs, in_stall is high because the store is in use.
// A queue of two vocabulary jobs sits between the front end and the engine.
// Reset is synchronous: it empties the queue, sets the maximum to the most
// negative logit, clears argmax, count and temperature; store contents are not cleared and need no sweep.
// A stalled output holds its result; the engine waits and the queue fills.
module temperature_token_sampler_core #(
  parameter int MAX_VOCAB = 65536
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tts_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tts_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [tts_pkg::TEMP_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(MAX_VOCAB);
  localparam int JOB_W = 2*AW + tts_pkg::LOGIT_W + tts_pkg::FRAC_W;

  logic [tts_pkg::TEMP_W-1:0] temperature;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_full;
  logic                       q_empty;
  logic [JOB_W-1:0]           q_in;
  logic [JOB_W-1:0]           q_head;
  logic                       back_busy;
  tts_pkg::store_wr_t         st_wr;
  logic [AW-1:0]              st_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature <= '0;
    end else if (cfg_we) begin
      temperature <= cfg_wdata;
    end
  end

  tts_front #(.MAX_VOCAB(MAX_VOCAB)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .temperature(temperature),
    .q_full(q_full), .q_empty(q_empty), .back_busy(back_busy),
    .q_push(q_push), .q_data(q_in),
    .st_wr(st_wr), .st_addr(st_addr)
  );

  tts_queue #(.W(JOB_W)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  tts_back #(.MAX_VOCAB(MAX_VOCAB)) u_back (
    .clk(clk), .rst(rst),
    .temperature(temperature),
    .q_empty(q_empty), .q_data(q_head), .q_pop(q_pop), .busy(back_busy),
    .st_wr(st_wr), .st_addr(st_addr),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

// File: src/tts_front.sv
// Front end: accepts logits, writes the store and tracks maximum and argmax.
module tts_front #(
  parameter int MAX_VOCAB = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tts_pkg::in_item_t                   in_data,
  input  logic [tts_pkg::TEMP_W-1:0]          temperature,
  input  logic                                q_full,
  input  logic                                q_empty,
  input  logic                                back_busy,
  output logic                                q_push,
  output logic [2*$clog2(MAX_VOCAB)+tts_pkg::LOGIT_W+tts_pkg::FRAC_W-1:0] q_data,
  output tts_pkg::store_wr_t                  st_wr,
  output logic [$clog2(MAX_VOCAB)-1:0]        st_addr
);

  localparam int AW    = $clog2(MAX_VOCAB);
  localparam int CNT_W = $clog2(MAX_VOCAB + 1);

  logic signed [tts_pkg::LOGIT_W-1:0] running_max;
  logic [AW-1:0]                      greedy_index;
  logic [CNT_W-1:0]                   logit_count;

  logic                               accept;
  logic                               room;
  logic                               new_max;
  logic signed [tts_pkg::LOGIT_W-1:0] max_after;
  logic [AW-1:0]                      greedy_after;
  logic [AW-1:0]                      last_idx;

  assign in_stall = q_full || ((temperature != '0) && (!q_empty || back_busy));
  assign accept   = in_valid && !in_stall;
  assign room     = logit_count < CNT_W'(MAX_VOCAB);
  assign new_max  = room && (in_data.logit > running_max);

  assign max_after    = new_max ? in_data.logit : running_max;
  assign greedy_after = new_max ? logit_count[AW-1:0] : greedy_index;
  assign last_idx     = room ? logit_count[AW-1:0] : AW'(MAX_VOCAB - 1);

  assign st_wr.en   = accept && room;
  assign st_wr.data = in_data.logit;
  assign st_addr    = logit_count[AW-1:0];

  assign q_push = accept && in_data.last_logit;
  assign q_data = {last_idx, max_after, greedy_after, in_data.random_fraction};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max  <= {1'b1, {(tts_pkg::LOGIT_W-1){1'b0}}};
      greedy_index <= '0;
      logit_count  <= '0;
    end else if (accept) begin
      if (in_data.last_logit) begin
        running_max  <= {1'b1, {(tts_pkg::LOGIT_W-1){1'b0}}};
        greedy_index <= '0;
        logit_count  <= '0;
      end else begin
        running_max  <= max_after;
        greedy_index <= greedy_after;
        if (room) begin
          logit_count <= logit_count + CNT_W'(1);
        end
      end
    end
  end

endmodule

// File: src/tts_queue.sv
// Two-entry job queue between the front end and the selection engine.
module tts_queue #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign head  = entry[rd_ptr];
  assign full  = count == 2'd2;
  assign empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// File: src/tts_back.sv
// Selection engine: weight pass, cumulative search and the output register.
`include "temperature_token_sampler_core_macros.svh"
module tts_back #(
  parameter int MAX_VOCAB = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [tts_pkg::TEMP_W-1:0]          temperature,
  input  logic                                q_empty,
  input  logic [2*$clog2(MAX_VOCAB)+tts_pkg::LOGIT_W+tts_pkg::FRAC_W-1:0] q_data,
  output logic                                q_pop,
  output logic                                busy,
  input  tts_pkg::store_wr_t                  st_wr,
  input  logic [$clog2(MAX_VOCAB)-1:0]        st_addr,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tts_pkg::out_item_t                  out_data
);

  localparam int AW = $clog2(MAX_VOCAB);
  localparam int DV_W = tts_pkg::TEMP_W + tts_pkg::QUO_W;

  tts_pkg::back_state_t state;
  tts_pkg::back_state_t state_next;

  logic signed [tts_pkg::LOGIT_W-1:0] store_mem [MAX_VOCAB];
  logic [tts_pkg::WEIGHT_W-1:0]       weight_mem [MAX_VOCAB];

  logic [AW-1:0]                      job_last;
  logic signed [tts_pkg::LOGIT_W-1:0] job_max;
  logic [tts_pkg::FRAC_W-1:0]         job_frac;

  logic [AW-1:0]                      k;
  logic signed [tts_pkg::LOGIT_W-1:0] store_q;
  logic [tts_pkg::WEIGHT_W-1:0]       weight_q;
  logic [tts_pkg::LOGIT_W-1:0]        rem;
  logic [DV_W-1:0]                    dv;
  logic [tts_pkg::QUO_W-1:0]          quo;
  logic [3:0]                         bitn;
  logic                               zero_w;
  logic [tts_pkg::EXP_W-1:0]          t1;
  logic [tts_pkg::SUM_W-1:0]          sum;
  logic [tts_pkg::SUM_W-1:0]          target;
  logic [tts_pkg::SUM_W-1:0]          cum;
  logic [AW-1:0]                      res_idx;
  logic                               res_greedy;

  logic [tts_pkg::LOGIT_W:0]          diff;
  logic [tts_pkg::LOGIT_W-1:0]        d;
  logic                               d_big;
  logic                               ge;
  logic [2*tts_pkg::EXP_W-1:0]        prod1;
  logic [2*tts_pkg::EXP_W-1:0]        prod2;
  logic [tts_pkg::EXP_W-1:0]          t2;
  logic [tts_pkg::WEIGHT_W-1:0]       w;
  logic [tts_pkg::FRAC_W+tts_pkg::SUM_W-1:0] prod_t;
  logic [tts_pkg::SUM_W-1:0]          cum_next;
  logic                               out_free;
  logic                               store_free;

  assign diff  = {job_max[tts_pkg::LOGIT_W-1], job_max} - {store_q[tts_pkg::LOGIT_W-1], store_q};
  assign d     = diff[tts_pkg::LOGIT_W-1:0];
  assign d_big = {{(DV_W-tts_pkg::LOGIT_W){1'b0}}, d} >= {temperature, {tts_pkg::QUO_W{1'b0}}};
  assign ge    = {{(DV_W-tts_pkg::LOGIT_W){1'b0}}, rem} >= dv;

  assign prod1 = tts_pkg::exp_int(quo[11:8]) * tts_pkg::exp_hi(quo[7:4])
               + (2*tts_pkg::EXP_W)'(32768);
  assign prod2 = t1 * tts_pkg::exp_lo(quo[3:0]) + (2*tts_pkg::EXP_W)'(32768);
  assign t2    = prod2[16 +: tts_pkg::EXP_W];
  assign w     = zero_w ? '0 : (t2[tts_pkg::EXP_W-1] ? '1 : t2[tts_pkg::WEIGHT_W-1:0]);

  assign prod_t     = job_frac * sum;
  assign cum_next   = cum + {{(tts_pkg::SUM_W-tts_pkg::WEIGHT_W){1'b0}}, weight_q};
  assign out_free   = !out_valid || !out_stall;
  assign busy       = state != tts_pkg::B_IDLE;
  assign store_free = (temperature == '0) || !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tts_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      tts_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = (temperature == '0) ? tts_pkg::B_OUT : tts_pkg::B_READ;
        end
      end
      tts_pkg::B_READ:  state_next = tts_pkg::B_SETUP;
      tts_pkg::B_SETUP: state_next = d_big ? tts_pkg::B_MUL2 : tts_pkg::B_DIV;
      tts_pkg::B_DIV: begin
        if (bitn == 4'd0) begin
          state_next = tts_pkg::B_MUL1;
        end
      end
      tts_pkg::B_MUL1: state_next = tts_pkg::B_MUL2;
      tts_pkg::B_MUL2: state_next = (k == job_last) ? tts_pkg::B_TARGET : tts_pkg::B_READ;
      tts_pkg::B_TARGET: state_next = tts_pkg::B_SREAD;
      tts_pkg::B_SREAD:  state_next = tts_pkg::B_SCMP;
      tts_pkg::B_SCMP: begin
        if ((target <= cum_next) || (k == job_last)) begin
          state_next = tts_pkg::B_OUT;
        end else begin
          state_next = tts_pkg::B_SREAD;
        end
      end
      tts_pkg::B_OUT: begin
        if (out_free) begin
          state_next = tts_pkg::B_IDLE;
        end
      end
      default: state_next = tts_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_wr.en) begin
      store_mem[st_addr] <= st_wr.data;
    end
    if (state == tts_pkg::B_MUL2) begin
      weight_mem[k] <= w;
    end
    store_q  <= store_mem[k];
    weight_q <= weight_mem[k];
  end

  always_ff @(posedge clk) begin
    case (state)
      tts_pkg::B_IDLE: begin
        {job_last, job_max, res_idx, job_frac} <= q_data;
        k          <= '0;
        sum        <= '0;
        res_greedy <= 1'b1;
      end
      tts_pkg::B_SETUP: begin
        rem    <= d;
        dv     <= {1'b0, temperature, {(tts_pkg::QUO_W-1){1'b0}}};
        quo    <= '0;
        bitn   <= 4'(tts_pkg::QUO_W - 1);
        zero_w <= d_big;
      end
      tts_pkg::B_DIV: begin
        if (ge) begin
          rem <= rem - dv[tts_pkg::LOGIT_W-1:0];
        end
        quo  <= {quo[tts_pkg::QUO_W-2:0], ge};
        dv   <= dv >> 1;
        bitn <= bitn - 4'd1;
      end
      tts_pkg::B_MUL1: begin
        t1 <= prod1[16 +: tts_pkg::EXP_W];
        if (quo[11:8] >= 4'(tts_pkg::EXPI_LEN)) begin
          zero_w <= 1'b1;
        end
      end
      tts_pkg::B_MUL2: begin
        sum <= sum + {{(tts_pkg::SUM_W-tts_pkg::WEIGHT_W){1'b0}}, w};
        if (k != job_last) begin
          k <= k + AW'(1);
        end
      end
      tts_pkg::B_TARGET: begin
        target <= prod_t[tts_pkg::FRAC_W +: tts_pkg::SUM_W];
        cum    <= '0;
        k      <= '0;
      end
      tts_pkg::B_SCMP: begin
        cum        <= cum_next;
        res_idx    <= k;
        res_greedy <= 1'b0;
        if (!((target <= cum_next) || (k == job_last))) begin
          k <= k + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tts_pkg::B_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tts_pkg::B_OUT && out_free) begin
      out_data.token_index <= tts_pkg::TOKEN_W'(res_idx);
      out_data.greedy_used <= res_greedy;
    end
  end

  `TTS_ASSERT_NOW(a_store_locked, st_wr.en, store_free, "store written during a sampling pass")
  `TTS_ASSERT_NEXT(a_sum_grows, state == tts_pkg::B_MUL2, sum >= $past(sum), "weight sum decreased")
  `TTS_ASSERT_NOW(a_search_bound, state == tts_pkg::B_SREAD, k <= job_last, "search index past vocabulary")

endmodule

// File: tb/tb_temperature_token_sampler_core.sv
// Self-checking testbench for the temperature token sampler core.
`timescale 1ns / 1ps

module tb_temperature_token_sampler_core;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_GOAL = 950;
  localparam int VOCAB_CAP = 65536;
  localparam int unsigned EXP_WHOLE[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
    22, 8, 3, 1};
  localparam int unsigned EXP_HIGH[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
    42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
  localparam int unsigned EXP_LOW[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
    63768, 63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  tts_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  tts_pkg::out_item_t out_data;
  logic cfg_we;
  logic [tts_pkg::TEMP_W-1:0] cfg_wdata;

  tts_pkg::in_item_t pending_logits[$];
  tts_pkg::out_item_t expected_tokens[$];
  logic signed [tts_pkg::LOGIT_W-1:0] vocab_logits[$];
  logic signed [tts_pkg::LOGIT_W-1:0] peak_logit;
  int unsigned peak_index;
  logic [tts_pkg::TEMP_W-1:0] temp_model;
  logic in_acc;
  int gap_left;
  int stall_left;
  int hold_left;
  int hold_req;
  int hold_served;
  bit quiet;
  int errors;
  int cycles;
  int items_sent;
  int vocabs_sent;
  int tokens_seen;
  int sampled_seen;

  temperature_token_sampler_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned exp_weight(int d, int unsigned t);
    int unsigned q;
    longint unsigned w;
    q = d / t;
    if ((q >> 8) >= 12) return 0;
    w = EXP_WHOLE[q >> 8];
    w = (w * EXP_HIGH[(q >> 4) & 15] + 32768) >> 16;
    w = (w * EXP_LOW[q & 15] + 32768) >> 16;
    if (w > 65535) w = 65535;
    return 32'(w);
  endfunction

  function automatic tts_pkg::out_item_t pick_token(logic [tts_pkg::FRAC_W-1:0] frac);
    tts_pkg::out_item_t r;
    longint unsigned total;
    longint unsigned target;
    longint unsigned cum;
    int n;
    n = vocab_logits.size();
    r.greedy_used = (temp_model == 0);
    if (temp_model == 0) begin
      r.token_index = peak_index[tts_pkg::TOKEN_W-1:0];
      return r;
    end
    total = 0;
    foreach (vocab_logits[k]) total += exp_weight(int'(peak_logit) - int'(vocab_logits[k]),
      temp_model);
    total &= 64'hFFFF_FFFF;
    target = (longint'(frac) * total) >> 16;
    r.token_index = 16'(n - 1);
    cum = 0;
    for (int k = 0; k < n; k++) begin
      cum += exp_weight(int'(peak_logit) - int'(vocab_logits[k]), temp_model);
      if (target <= cum) begin
        r.token_index = 16'(k);
        break;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Predictor and checker: both sides are sampled at the rising edge.
  always @(posedge clk) begin
    in_acc <= !rst && in_valid && !in_stall;
    if (rst) begin
      vocab_logits.delete();
      peak_logit = -32768;
      peak_index = 0;
      temp_model = 0;
    end else begin
      if (cfg_we) temp_model = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (vocab_logits.size() < VOCAB_CAP) begin
          if (in_data.logit > peak_logit) begin
            peak_logit = in_data.logit;
            peak_index = vocab_logits.size();
          end
          vocab_logits.push_back(in_data.logit);
        end
        if (in_data.last_logit) begin
          expected_tokens.push_back(pick_token(in_data.random_fraction));
          vocab_logits.delete();
          peak_logit = -32768;
          peak_index = 0;
        end
      end
      if (out_valid && !out_stall) begin
        tokens_seen++;
        if (!out_data.greedy_used) sampled_seen++;
        if (expected_tokens.size() == 0) begin
          errors++;
          $display("%0t: unexpected token transfer: index %0d greedy %0b", $time,
            out_data.token_index, out_data.greedy_used);
        end else begin
          tts_pkg::out_item_t e;
          e = expected_tokens.pop_front();
          if (out_data.token_index !== e.token_index) begin
            errors++;
            $display("%0t: token_index expected %0d actual %0d", $time, e.token_index,
              out_data.token_index);
          end
          if (out_data.greedy_used !== e.greedy_used) begin
            errors++;
            $display("%0t: greedy_used expected %0b actual %0b", $time, e.greedy_used,
              out_data.greedy_used);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || in_acc) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_logits.size() > 0) begin
        in_data <= pending_logits.pop_front();
        in_valid <= 1'b1;
        if (quiet || $urandom_range(0, 99) < 65) gap_left = 0;
        else if ($urandom_range(0, 99) < 88) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(10, 40);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      hold_served = 0;
    end else if (hold_req != hold_served) begin
      hold_served = hold_req;
      hold_left = 1500;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (quiet || $urandom_range(0, 99) < 70) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end
  end

  task automatic push_logit(logic signed [tts_pkg::LOGIT_W-1:0] v, bit last,
                            logic [tts_pkg::FRAC_W-1:0] frac);
    tts_pkg::in_item_t it;
    it.logit = v;
    it.last_logit = last;
    it.random_fraction = frac;
    pending_logits.push_back(it);
    items_sent++;
    if (last) vocabs_sent++;
  endtask

  task automatic push_vocab(int n, int spread, logic [tts_pkg::FRAC_W-1:0] frac);
    int base;
    int v;
    base = $signed(16'($urandom));
    for (int k = 0; k < n; k++) begin
      if (spread == 0) v = $signed(16'($urandom));
      else begin
        v = base + $urandom_range(0, spread) - spread / 2;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      push_logit(16'(v), k == n - 1, (k == n - 1) ? frac : 16'($urandom));
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_logits.size() > 0 || in_valid || expected_tokens.size() > 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_temperature(logic [tts_pkg::TEMP_W-1:0] t, bit calm);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_we <= 1'b0;
    quiet = calm;
  endtask

  initial begin
    int t;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_req = 0;
    quiet = 0;
    errors = 0;
    cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Greedy extremes, ties on the maximum and a vocabulary of one logit.
    set_temperature(0, 0);
    push_logit(32767, 0, 16'hFFFF);
    push_logit(-32768, 0, 0);
    push_logit(32767, 1, 16'h5555);
    push_logit(-32768, 1, 16'hAAAA);
    push_logit(-32768, 0, 0);
    push_logit(-32768, 1, 0);
    push_logit(0, 0, 0);
    push_logit(5, 0, 0);
    push_logit(5, 0, 0);
    push_logit(1, 1, 0);
    // Sampling at the extremes of the random fraction and of the spread.
    set_temperature(1, 0);
    push_logit(100, 0, 0);
    push_logit(100, 0, 0);
    push_logit(-32768, 0, 0);
    push_logit(32767, 1, 0);
    push_logit(100, 0, 0);
    push_logit(101, 0, 0);
    push_logit(-32768, 1, 16'hFFFF);
    set_temperature(255, 0);
    push_logit(-32768, 0, 0);
    push_logit(32767, 0, 0);
    push_logit(0, 0, 0);
    push_logit(32000, 1, 16'hFFFF);
    push_logit(7, 1, 16'h8000);

    // The receiver holds off while the sender keeps offering vocabularies.
    set_temperature(0, 1);
    hold_req++;
    for (int k = 0; k < 12; k++) push_vocab($urandom_range(2, 4), 0, 16'($urandom));

    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 4))
        0: t = 0;
        1: t = 1;
        2: t = 255;
        default: t = $urandom_range(2, 254);
      endcase
      set_temperature(8'(t), $urandom_range(0, 5) == 0);
      for (int k = 0; k < 6; k++) begin
        int spread;
        case ($urandom_range(0, 3))
          0: spread = 0;
          1: spread = 16;
          2: spread = 256;
          default: spread = 2048;
        endcase
        push_vocab(($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10),
          spread, 16'($urandom));
      end
    end
    drain();

    $display("Sent %0d logits in %0d vocabularies; checked %0d tokens, %0d of them sampled.",
      items_sent, vocabs_sent, tokens_seen, sampled_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: temperature_token_sampler_core.f
+incdir+src
src/tts_pkg.sv
src/tts_front.sv
src/tts_queue.sv
src/tts_back.sv
src/temperature_token_sampler_core.sv
tb/tb_temperature_token_sampler_core.sv
